FILE: rtl/dhat_pkg.sv
// ----------------------------------------------------------------------------
// dhat_pkg
// Shared widths, reset values, register indexes and attenuation ROMs for the
// depth haze attenuation table.
// ----------------------------------------------------------------------------
package dhat_pkg;

  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned DENS_W     = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // depth parameter t, Q8.16
  localparam int unsigned T_W     = 24;
  // Q0.16 values with 1.0 held in a 17th bit
  localparam int unsigned EXP_W   = 17;
  localparam logic [EXP_W-1:0] EXP_ONE = 17'h10000;

  localparam int unsigned MAX_TABLE_SIZE_DEF = 1024;

  localparam logic [DIST_W-1:0]  NEAR_RST  = 24'h000000;
  localparam logic [DIST_W-1:0]  FAR_RST   = 24'h010000;
  localparam logic [DENS_W-1:0]  DENS_RST  = 24'h100000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'hFF;
  localparam int unsigned        SIZE_RST  = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR  = 3'd0,
    CFG_FAR   = 3'd1,
    CFG_DENS  = 3'd2,
    CFG_MODE  = 3'd3,
    CFG_ALPHA = 3'd4,
    CFG_SIZE  = 3'd5
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR = 2'd0,
    MODE_EXP    = 2'd1,
    MODE_EXP2   = 2'd2
  } haze_mode_e;

  // round(65536*exp(-k)), zero from k = 12 on
  function automatic logic [EXP_W-1:0] int_exp(input logic [3:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  typedef logic [255:0][EXP_W-1:0] frac_rom_t;

  // floor(num / den) by shift and subtract, used only while building the ROM
  function automatic longint unsigned series_quot(input longint unsigned num,
                                                  input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(65536*exp(-j/256)) from an alternating series in Q0.52
  function automatic frac_rom_t build_frac_rom();
    frac_rom_t       rom;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    int              j;
    int              n;
    for (j = 0; j < 256; j++) begin
      term = 64'd1 << 52;
      pos  = term;
      neg  = 64'd0;
      for (n = 1; n <= 24; n++) begin
        term = series_quot(term * 64'(j), 64'd256 * 64'(n));
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      rom[j] = EXP_W'(((pos - neg) + (64'd1 << 35)) >> 36);
    end
    return rom;
  endfunction

  localparam frac_rom_t FRAC_ROM = build_frac_rom();

endpackage

FILE: rtl/depth_haze_attenuation_table.sv
// ----------------------------------------------------------------------------
// depth_haze_attenuation_table
// Haze table entry: depth parameter from span, density and index, then a
// linear, exponential or squared exponential attenuation curve.
// ----------------------------------------------------------------------------
// Takes one entry index per cycle while no stall holds the input and returns
// one haze byte and visibility flag per index, in order. The pipeline has two
// multiply stages, a restoring divider by the table size spread over three
// stages of eight quotient bits, a squaring stage, a ROM stage, an exponent
// multiply, a curve select and the output register.
// Stages that hold no request absorb stalls, so the input keeps accepting
// while a result waits. Configuration writes take effect at once and must be
// made only while no request is in flight.
module depth_haze_attenuation_table
  import dhat_pkg::*;
#(
  parameter int unsigned MAX_TABLE_SIZE = MAX_TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INDEX_W-1:0]    entry_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     haze_byte_o,
  output logic                  visible_o
);

  localparam int unsigned SizeMaxReg = (1 << SIZE_W) - 1;
  localparam int unsigned SizeCap    =
      (MAX_TABLE_SIZE < SizeMaxReg) ? MAX_TABLE_SIZE : SizeMaxReg;
  localparam int unsigned SizeW      = $clog2(SizeCap + 1);
  localparam int unsigned SizeRstVal = (SIZE_RST > SizeCap) ? SizeCap : SIZE_RST;

  localparam int unsigned ProdW   = DIST_W + DENS_W;
  localparam int unsigned NumW    = ProdW + INDEX_W;
  localparam int unsigned NqW     = NumW - 12;
  localparam int unsigned HiW     = NqW - T_W;
  localparam int unsigned SqW     = 2 * T_W;

  localparam int unsigned DivStages = 3;
  localparam int unsigned DivSteps  = T_W / DivStages;

  localparam int unsigned StA    = 0;
  localparam int unsigned StB    = 1;
  localparam int unsigned StDiv0 = 2;
  localparam int unsigned StF    = StDiv0 + DivStages;
  localparam int unsigned StG    = StF + 1;
  localparam int unsigned StH    = StG + 1;
  localparam int unsigned StI    = StH + 1;
  localparam int unsigned StJ    = StI + 1;
  localparam int unsigned NumSt  = StJ + 1;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  near_q, far_q, span_q;
  logic [DENS_W-1:0]  density_q;
  haze_mode_e         mode_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [SizeW-1:0]   size_q;
  logic [SIZE_W-1:0]  size_raw;
  logic [SizeW-1:0]   size_clamped;

  assign cfg_ready_o = 1'b1;
  assign size_raw    = cfg_data_i[SIZE_W-1:0];

  always_comb begin
    if (size_raw == '0) begin
      size_clamped = SizeW'(1);
    end else if (size_raw > SIZE_W'(SizeCap)) begin
      size_clamped = SizeW'(SizeCap);
    end else begin
      size_clamped = SizeW'(size_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q    <= NEAR_RST;
      far_q     <= FAR_RST;
      span_q    <= FAR_RST - NEAR_RST;
      density_q <= DENS_RST;
      mode_q    <= MODE_LINEAR;
      alpha_q   <= ALPHA_RST;
      size_q    <= SizeW'(SizeRstVal);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NEAR: begin
          near_q <= cfg_data_i[DIST_W-1:0];
          span_q <= (far_q > cfg_data_i[DIST_W-1:0]) ? far_q - cfg_data_i[DIST_W-1:0] : '0;
        end
        CFG_FAR: begin
          far_q  <= cfg_data_i[DIST_W-1:0];
          span_q <= (cfg_data_i[DIST_W-1:0] > near_q) ? cfg_data_i[DIST_W-1:0] - near_q : '0;
        end
        CFG_DENS:  density_q <= cfg_data_i[DENS_W-1:0];
        CFG_MODE:  mode_q    <= haze_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_ALPHA: alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        CFG_SIZE:  size_q    <= size_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NumSt-1:0] v_q, v_d, en;

  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || out_ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumSt; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[StA];
  assign out_valid_o = v_q[StJ];

  // ---------------------------------------------------------------------------
  // Stages A, B: num = span * density * index, drop the low 12 bits
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0]   prod_a_q;
  logic [INDEX_W-1:0] idx_a_q;
  logic [NumW-1:0]    num_b;
  logic [NqW-1:0]     nq_b_q;

  assign num_b = NumW'(prod_a_q) * NumW'(idx_a_q);

  always_ff @(posedge clk_i) begin
    if (en[StA]) begin
      prod_a_q <= ProdW'(span_q) * ProdW'(density_q);
      idx_a_q  <= entry_index_i;
    end
    if (en[StB]) begin
      nq_b_q <= num_b[NumW-1:12];
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: t = nq / size, saturated to T_W bits
  // ---------------------------------------------------------------------------
  logic [SizeW-1:0] div_rem_q [DivStages-1];
  logic [T_W-1:0]   div_dvd_q [DivStages-1];
  logic [T_W-1:0]   div_quo_q [DivStages];
  logic             div_sat_q [DivStages];

  for (genvar d = 0; d < DivStages; d++) begin : g_div
    logic [SizeW-1:0] rem_in, rem;
    logic [T_W-1:0]   dvd_in, dvd, quo_in, quo;
    logic             sat_in;
    logic [SizeW:0]   ext;

    if (d == 0) begin : g_first
      assign rem_in = nq_b_q[T_W +: SizeW];
      assign dvd_in = nq_b_q[T_W-1:0];
      assign quo_in = '0;
      assign sat_in = nq_b_q[NqW-1:T_W] >= HiW'(size_q);
    end else begin : g_next
      assign rem_in = div_rem_q[d-1];
      assign dvd_in = div_dvd_q[d-1];
      assign quo_in = div_quo_q[d-1];
      assign sat_in = div_sat_q[d-1];
    end

    always_comb begin
      rem = rem_in;
      dvd = dvd_in;
      quo = quo_in;
      ext = '0;
      for (int s = 0; s < DivSteps; s++) begin
        ext = {rem, dvd[T_W-1]};
        dvd = {dvd[T_W-2:0], 1'b0};
        if (ext >= {1'b0, size_q}) begin
          ext = ext - {1'b0, size_q};
          quo = {quo[T_W-2:0], 1'b1};
        end else begin
          quo = {quo[T_W-2:0], 1'b0};
        end
        rem = ext[SizeW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StDiv0+d]) begin
        div_quo_q[d] <= quo;
        div_sat_q[d] <= sat_in;
      end
    end

    if (d < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[StDiv0+d]) begin
          div_rem_q[d] <= rem;
          div_dvd_q[d] <= dvd;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: t and t squared
  // ---------------------------------------------------------------------------
  logic [T_W-1:0] t_f;
  logic [T_W-1:0] t_f_q;
  logic [SqW-1:0] sq_f_q;

  assign t_f = div_sat_q[DivStages-1] ? '1 : div_quo_q[DivStages-1];

  always_ff @(posedge clk_i) begin
    if (en[StF]) begin
      t_f_q  <= t_f;
      sq_f_q <= SqW'(t_f) * SqW'(t_f);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: exponent argument, ROM reads, linear curve
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]    x_g;
  logic [T_W:0]      lin_sum;
  logic [BYTE_W-1:0] lin_g;
  logic [EXP_W-1:0]  ie_g_q, fe_g_q;
  logic [BYTE_W-1:0] lin_g_q;

  always_comb begin
    if (mode_q == MODE_EXP2) begin
      x_g = (sq_f_q[SqW-1:T_W+16] != '0) ? '1 : sq_f_q[T_W+15:16];
    end else begin
      x_g = t_f_q;
    end
    lin_sum = (T_W+1)'({t_f_q[15:0], 8'h00}) - (T_W+1)'(t_f_q[15:0]) + (T_W+1)'(32768);
    lin_g   = (t_f_q[T_W-1:16] != '0) ? '1 : lin_sum[T_W-1:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[StG]) begin
      ie_g_q  <= (x_g[T_W-1:20] == '0) ? int_exp(x_g[19:16]) : '0;
      fe_g_q  <= FRAC_ROM[x_g[15:8]];
      lin_g_q <= lin_g;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage H: e = round(ie * fe / 65536)
  // ---------------------------------------------------------------------------
  logic [2*EXP_W-1:0] p_h;
  logic [EXP_W:0]     e_h;
  logic [EXP_W-1:0]   e_h_q;
  logic [BYTE_W-1:0]  lin_h_q;

  always_comb begin
    p_h = (2*EXP_W)'(ie_g_q) * (2*EXP_W)'(fe_g_q) + (2*EXP_W)'(32768);
    e_h = p_h[2*EXP_W-1:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[StH]) begin
      e_h_q   <= (e_h > (EXP_W+1)'(EXP_ONE)) ? EXP_ONE : e_h[EXP_W-1:0];
      lin_h_q <= lin_g_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage I: curve select
  // ---------------------------------------------------------------------------
  logic [EXP_W-1:0]  om_i;
  logic [T_W:0]      exp_sum;
  logic [BYTE_W-1:0] hb_i;
  logic [BYTE_W-1:0] hb_i_q;

  always_comb begin
    om_i    = EXP_ONE - e_h_q;
    exp_sum = (T_W+1)'({om_i, 8'h00}) - (T_W+1)'(om_i) + (T_W+1)'(32768);
    case (mode_q)
      MODE_LINEAR: hb_i = lin_h_q;
      MODE_EXP,
      MODE_EXP2:   hb_i = exp_sum[T_W-1:16];
      default:     hb_i = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[StI]) begin
      hb_i_q <= hb_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage J: output register and visibility
  // ---------------------------------------------------------------------------
  logic [BYTE_W+ALPHA_W-1:0] vis_prod;

  assign vis_prod = (BYTE_W+ALPHA_W)'(hb_i_q) * (BYTE_W+ALPHA_W)'(alpha_q);

  always_ff @(posedge clk_i) begin
    if (en[StJ]) begin
      haze_byte_o <= hb_i_q;
      visible_o   <= vis_prod[BYTE_W+ALPHA_W-1:8] != '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled with a free pipeline stage");

  a_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_q == ((far_q > near_q) ? far_q - near_q : '0))
    else $error("span register out of step with near and far");

  a_size_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q != '0) && (size_q <= SizeW'(SizeCap)))
    else $error("table size outside its clamped range");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StDiv0] && !div_sat_q[0] |-> div_rem_q[0] < size_q)
    else $error("divider remainder not below the divisor");

endmodule

FILE: test/depth_haze_attenuation_table_test.sv
// ----------------------------------------------------------------------------
// depth_haze_attenuation_table_test
// Self-checking bench for the depth haze attenuation table. A driver and a
// monitor run as clocked processes around the block. Each accepted index is
// turned into an expected haze byte and visibility flag by a local model of
// the depth, curve and ROM arithmetic. Results are checked in order. A short
// directed set covers the curves and corner cases. Random phases then vary
// the configuration and the sender and receiver idling.
// ----------------------------------------------------------------------------
module depth_haze_attenuation_table_test;
  import dhat_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] level;
    logic              vis;
  } haze_t;

  localparam int unsigned               CYCLE_LIMIT   = 200000;
  localparam logic [MODE_W-1:0]         MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0]      CFG_SPARE_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0]      CFG_SPARE_HI  = 3'd7;
  localparam int unsigned               RANDOM_PHASES = 14;
  localparam int unsigned               PHASE_ITEMS   = 125;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [INDEX_W-1:0]    entry_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [BYTE_W-1:0]     haze_byte_o;
  logic                  visible_o;

  // configuration as the block should hold it
  logic [DIST_W-1:0]  near_q  = NEAR_RST;
  logic [DIST_W-1:0]  far_q   = FAR_RST;
  logic [DENS_W-1:0]  dens_q  = DENS_RST;
  logic [MODE_W-1:0]  mode_q  = MODE_LINEAR;
  logic [ALPHA_W-1:0] alpha_q = ALPHA_RST;
  logic [SIZE_W-1:0]  size_q  = SIZE_W'(SIZE_RST);

  int unsigned whole_decay [16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                    22, 8, 3, 1, 0, 0, 0, 0};

  logic [INDEX_W-1:0] index_backlog [$];
  haze_t              haze_due [$];
  haze_t              want;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        err_count = 0;
  int unsigned        cycle_count = 0;

  depth_haze_attenuation_table dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // round(65536*exp(-j/256)), alternating series held in Q0.52
  function automatic longint unsigned frac_decay(input logic [7:0] j);
    longint unsigned term;
    longint unsigned up;
    longint unsigned down;
    term = 64'd1 << 52;
    up   = term;
    down = 64'd0;
    for (int n = 1; n <= 24; n++) begin
      term = (term * j) / (64'd256 * 64'(n));
      if (n % 2 == 1) begin
        down = down + term;
      end else begin
        up = up + term;
      end
    end
    return ((up - down) + (64'd1 << 35)) >> 36;
  endfunction

  function automatic haze_t haze_for(input logic [INDEX_W-1:0] idx);
    longint unsigned size;
    longint unsigned span;
    longint unsigned depth;
    longint unsigned arg;
    longint unsigned decay;
    longint unsigned level;
    haze_t           r;
    size = (size_q == 0) ? 64'd1 :
           (size_q > MAX_TABLE_SIZE_DEF) ? 64'(MAX_TABLE_SIZE_DEF) : 64'(size_q);
    span  = (far_q > near_q) ? 64'(far_q - near_q) : 64'd0;
    depth = ((span * 64'(dens_q) * 64'(idx)) / size) >> 12;
    if (depth > 64'hFFFFFF) begin
      depth = 64'hFFFFFF;
    end
    level = 64'd0;
    case (mode_q)
      MODE_LINEAR: begin
        level = (depth >= 64'd65536) ? 64'd255 : (64'd255 * depth + 64'd32768) >> 16;
      end
      MODE_EXP, MODE_EXP2: begin
        arg = depth;
        if (mode_q == MODE_EXP2) begin
          arg = (depth * depth) >> 16;
          if (arg > 64'hFFFFFF) begin
            arg = 64'hFFFFFF;
          end
        end
        decay = ((arg >> 16) < 64'd16) ? 64'(whole_decay[arg >> 16]) : 64'd0;
        decay = (decay * frac_decay(arg[15:8]) + 64'd32768) >> 16;
        if (decay > 64'd65536) begin
          decay = 64'd65536;
        end
        level = (64'd255 * (64'd65536 - decay) + 64'd32768) >> 16;
      end
      default: begin
        level = 64'd0;
      end
    endcase
    r.level = level[BYTE_W-1:0];
    r.vis   = ((level * 64'(alpha_q)) >> 8) != 64'd0;
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      entry_index_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        haze_due.push_back(haze_for(entry_index_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (index_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          entry_index_i <= index_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (haze_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got haze_byte %0d visible %0d",
                   $time, haze_byte_o, visible_o);
        end else begin
          want = haze_due.pop_front();
          if (haze_byte_o !== want.level) begin
            err_count++;
            $display("%0t: haze_byte mismatch, expected %0d, got %0d",
                     $time, want.level, haze_byte_o);
          end
          if (visible_o !== want.vis) begin
            err_count++;
            $display("%0t: visible mismatch, expected %0d, got %0d",
                     $time, want.vis, visible_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("depth_haze_attenuation_table verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NEAR:  near_q  = data[DIST_W-1:0];
      CFG_FAR:   far_q   = data[DIST_W-1:0];
      CFG_DENS:  dens_q  = data[DENS_W-1:0];
      CFG_MODE:  mode_q  = data[MODE_W-1:0];
      CFG_ALPHA: alpha_q = data[ALPHA_W-1:0];
      CFG_SIZE:  size_q  = data[SIZE_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [23:0] n, input logic [23:0] f, input logic [23:0] d,
                           input logic [23:0] m, input logic [23:0] a, input logic [23:0] s);
    write_reg(CFG_NEAR, n);
    write_reg(CFG_FAR, f);
    write_reg(CFG_DENS, d);
    write_reg(CFG_MODE, m);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_SIZE, s);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (index_backlog.size() != 0 || in_valid_i || haze_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // log-spread value with the extremes weighted in
  function automatic logic [23:0] spread24();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return '0;
    end
    if (sel == 1) begin
      return '1;
    end
    return 24'($urandom) >> $urandom_range(0, 23);
  endfunction

  initial begin
    logic [23:0] near_v;
    logic [24:0] far_sum;
    logic [23:0] far_v;
    logic [23:0] mode_v;
    logic [23:0] alpha_v;
    logic [23:0] size_v;
    int unsigned eff_size;
    int unsigned sel;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: linear, t reaches 1.0 at index 4
    index_backlog.push_back(10'd0);
    index_backlog.push_back(10'd1);
    index_backlog.push_back(10'd3);
    index_backlog.push_back(10'd4);
    index_backlog.push_back(10'd1023);
    drain();

    configure(24'h0, 24'h000400, 24'h100000, 24'(MODE_EXP), 24'd255, 24'd1024);
    index_backlog.push_back(10'd0);
    index_backlog.push_back(10'd256);
    index_backlog.push_back(10'd1023);
    drain();

    configure(24'h0, 24'h000400, 24'h100000, 24'(MODE_EXP2), 24'd0, 24'd1024);
    index_backlog.push_back(10'd128);
    index_backlog.push_back(10'd512);
    index_backlog.push_back(10'd1023);
    drain();

    // empty span, far below near and far equal to near
    configure(24'hFFFFFF, 24'h0, 24'h100000, 24'(MODE_EXP), 24'd255, 24'd1024);
    index_backlog.push_back(10'd1023);
    drain();
    configure(24'h123456, 24'h123456, 24'hFFFFFF, 24'(MODE_LINEAR), 24'd255, 24'd1024);
    index_backlog.push_back(10'd1023);
    drain();

    configure(24'h0, 24'h000400, 24'h100000, 24'(MODE_UNUSED), 24'd255, 24'd1024);
    index_backlog.push_back(10'd1023);
    drain();

    // zero size, full span and density, saturated t
    configure(24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'(MODE_LINEAR), 24'd1, 24'd0);
    index_backlog.push_back(10'd1023);
    index_backlog.push_back(10'd0);
    drain();

    // oversized table, then indexes past a small table
    configure(24'h0, 24'h000400, 24'h100000, 24'(MODE_EXP2), 24'd128, 24'd2047);
    index_backlog.push_back(10'd1023);
    drain();
    configure(24'h0, 24'h000400, 24'h100000, 24'(MODE_EXP2), 24'd128, 24'd5);
    index_backlog.push_back(10'd5);
    index_backlog.push_back(10'd1023);
    drain();

    // bits above each register's width
    configure(24'h0, 24'h000100, 24'h100000, 24'hFFFFF1, 24'hABCD80, 24'hFFF810);
    index_backlog.push_back(10'd3);
    index_backlog.push_back(10'd15);
    drain();

    write_reg(CFG_SPARE_HI, 24'hFFFFFF);
    write_reg(CFG_SPARE_LO, 24'h0);
    @(negedge clk_i);
    index_backlog.push_back(10'd1);
    index_backlog.push_back(10'd2);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase

      near_v  = spread24();
      far_sum = {1'b0, near_v} + {1'b0, spread24()};
      far_v   = far_sum[24] ? 24'hFFFFFF : far_sum[23:0];
      if ($urandom_range(0, 7) == 0) begin
        far_v = spread24();
      end

      sel    = $urandom_range(0, 7);
      mode_v = 24'($urandom);
      mode_v[MODE_W-1:0] = (sel == 7) ? MODE_UNUSED : MODE_W'(sel % 3);
      if ($urandom_range(0, 1) == 0) begin
        mode_v[23:MODE_W] = '0;
      end

      sel     = $urandom_range(0, 5);
      alpha_v = 24'($urandom);
      if (sel == 0) begin
        alpha_v[ALPHA_W-1:0] = '0;
      end else if (sel == 1) begin
        alpha_v[ALPHA_W-1:0] = '1;
      end else if (sel == 2) begin
        alpha_v[ALPHA_W-1:0] = 8'd1;
      end
      if ($urandom_range(0, 1) == 0) begin
        alpha_v[23:ALPHA_W] = '0;
      end

      sel    = $urandom_range(0, 7);
      size_v = 24'($urandom);
      if (sel == 0) begin
        size_v[SIZE_W-1:0] = SIZE_W'(MAX_TABLE_SIZE_DEF);
      end else if (sel == 1) begin
        size_v[SIZE_W-1:0] = '0;
      end else if (sel == 2) begin
        size_v[SIZE_W-1:0] = SIZE_W'($urandom_range(MAX_TABLE_SIZE_DEF + 1, 2047));
      end else begin
        size_v[SIZE_W-1:0] = SIZE_W'($urandom_range(1, MAX_TABLE_SIZE_DEF));
      end
      if ($urandom_range(0, 1) == 0) begin
        size_v[23:SIZE_W] = '0;
      end

      configure(near_v, far_v, spread24(), mode_v, alpha_v, size_v);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
        @(negedge clk_i);
      end

      eff_size = (size_q == 0) ? 1 :
                 (size_q > MAX_TABLE_SIZE_DEF) ? MAX_TABLE_SIZE_DEF : size_q;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          index_backlog.push_back(INDEX_W'($urandom_range(0, eff_size - 1)));
        end else begin
          index_backlog.push_back(INDEX_W'($urandom));
        end
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("depth_haze_attenuation_table verification clean");
    end else begin
      $display("depth_haze_attenuation_table verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dhat_pkg.sv
rtl/depth_haze_attenuation_table.sv
test/depth_haze_attenuation_table_test.sv
